@@ rtl/core/mmnv_pkg.sv @@
// Shared types, MIDI status codes and bend scaling for the mono note voicer.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package mmnv_pkg;

  localparam int MaxMsgs = 3;
  localparam int CountW  = $clog2(MaxMsgs + 1);

  localparam logic [7:0]  StNoteOn    = 8'h90;
  localparam logic [7:0]  StNoteOff   = 8'h80;
  localparam logic [7:0]  StBend      = 8'hE0;
  localparam logic [6:0]  Velocity    = 7'd64;
  localparam logic [13:0] BendCenter  = 14'd8192;
  localparam logic [15:0] BendPosMul  = 16'd8191;
  localparam logic [28:0] BendPosRnd  = 29'd16384;

  localparam logic OpPitch   = 1'b0;
  localparam logic OpUnvoice = 1'b1;

  typedef struct packed {
    logic [7:0]  status_byte;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic [15:0] time_stamp;
    logic        last;
  } msg_t;

  typedef struct packed {
    msg_t [MaxMsgs-1:0]  msgs;   // msgs[0] goes out first
    logic [CountW-1:0]   count;
  } batch_t;

  // 14-bit bend word: center plus bend scaled by 8191/32768 (positive) or
  // 8192/32768 (negative), rounded half away from zero.
  function automatic logic [13:0] bend_value(input logic [15:0] raw);
    logic [16:0] mag;
    logic [16:0] rnd_neg;
    logic [28:0] prod;
    logic [28:0] rnd_pos;
    logic [13:0] res;
    mag     = 17'h10000 - {1'b0, raw};
    rnd_neg = (mag + 17'd2) >> 2;
    prod    = {13'd0, raw} * {13'd0, BendPosMul};
    rnd_pos = (prod + BendPosRnd) >> 15;
    if (raw[15]) begin
      res = BendCenter - rnd_neg[13:0];
    end else begin
      res = BendCenter + rnd_pos[13:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/midi_mono_note_voicer_top.sv @@
// Mono MIDI note voicer, channel 0: pitch and unvoice transactions in,
// note-off / note-on / pitch-bend messages out. Uses mmnv_pkg, mmnv_decode,
// mmnv_msg_queue.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one transaction: operation,
//   target note, Q1.15 bend and frame offset. Output channel (out_valid /
//   out_stall) delivers zero to three messages per transaction, each stamped
//   with the frame offset; out_last marks the final message of a transaction.
//   cfg_wr_en / cfg_wr_data write output_enabled; write only while idle.
// Output: the first message appears the cycle after the transaction is taken.
// Throughput: one message per cycle while out_stall is low. The next
//   transaction is taken in the cycle its predecessor's last message leaves,
//   set by the three-entry message queue.
// Reset: clears the queue, the sounding note and output_enabled.
// Stall: a stalled message holds; in_stall is high while more than one
//   message is pending, or while the last pending message is stalled.
`timescale 1ns / 1ps

module midi_mono_note_voicer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [6:0]  in_note_number,
  input  logic [15:0] in_bend,
  input  logic [15:0] in_frame_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_status_byte,
  output logic [6:0]  out_data_one,
  output logic [6:0]  out_data_two,
  output logic [15:0] out_time_stamp,
  output logic        out_last
);

  logic             output_enabled_r;
  logic [6:0]       note_r, note_nxt;
  logic             load;
  mmnv_pkg::batch_t batch;
  mmnv_pkg::msg_t   out_msg;

  assign load = in_valid && !in_stall;

  mmnv_decode u_decode (
    .operation      (in_operation),
    .note_number    (in_note_number),
    .bend           (in_bend),
    .frame_offset   (in_frame_offset),
    .output_enabled (output_enabled_r),
    .sounding_note  (note_r),
    .batch          (batch),
    .note_nxt       (note_nxt)
  );

  mmnv_msg_queue u_queue (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .batch         (batch),
    .can_load_hold (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_msg       (out_msg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_enabled_r <= 1'b0;
      note_r           <= 7'd0;
    end else begin
      if (cfg_wr_en) begin
        output_enabled_r <= cfg_wr_data;
      end
      if (load) begin
        note_r <= note_nxt;
      end
    end
  end

  assign out_status_byte = out_msg.status_byte;
  assign out_data_one    = out_msg.data_one;
  assign out_data_two    = out_msg.data_two;
  assign out_time_stamp  = out_msg.time_stamp;
  assign out_last        = out_msg.last;

endmodule

@@ rtl/core/mmnv_decode.sv @@
// Turns one input transaction into up to three MIDI messages and the next note.
// Purely combinational; uses mmnv_pkg types, codes and bend_value.
`timescale 1ns / 1ps

module mmnv_decode (
  input  logic                 operation,
  input  logic [6:0]           note_number,
  input  logic [15:0]          bend,
  input  logic [15:0]          frame_offset,
  input  logic                 output_enabled,
  input  logic [6:0]           sounding_note,
  output mmnv_pkg::batch_t     batch,
  output logic [6:0]           note_nxt
);

  mmnv_pkg::msg_t off_msg;
  mmnv_pkg::msg_t on_msg;
  mmnv_pkg::msg_t bend_msg;
  mmnv_pkg::msg_t idle_msg;
  logic [13:0]    bv;
  logic           need_off;
  logic           need_on;

  assign bv = mmnv_pkg::bend_value(bend);

  always_comb begin
    off_msg  = '{status_byte: mmnv_pkg::StNoteOff, data_one: sounding_note,
                 data_two: mmnv_pkg::Velocity, time_stamp: frame_offset, last: 1'b0};
    on_msg   = '{status_byte: mmnv_pkg::StNoteOn, data_one: note_number,
                 data_two: mmnv_pkg::Velocity, time_stamp: frame_offset, last: 1'b0};
    bend_msg = '{status_byte: mmnv_pkg::StBend, data_one: bv[6:0],
                 data_two: bv[13:7], time_stamp: frame_offset, last: 1'b1};
    idle_msg = off_msg;
  end

  assign need_on  = (sounding_note != note_number);
  assign need_off = need_on && (sounding_note != 7'd0);

  always_comb begin
    batch.msgs  = {idle_msg, idle_msg, idle_msg};
    batch.count = '0;
    note_nxt    = sounding_note;
    if (operation == mmnv_pkg::OpUnvoice) begin
      if (sounding_note != 7'd0) begin
        note_nxt = 7'd0;
        if (output_enabled) begin
          batch.msgs[0]      = off_msg;
          batch.msgs[0].last = 1'b1;
          batch.count        = mmnv_pkg::CountW'(1);
        end
      end
    end else if (output_enabled) begin
      if (need_on) begin
        note_nxt = note_number;
      end
      case ({need_off, need_on})
        2'b11: begin
          batch.msgs[0] = off_msg;
          batch.msgs[1] = on_msg;
          batch.msgs[2] = bend_msg;
          batch.count   = mmnv_pkg::CountW'(3);
        end
        2'b01: begin
          batch.msgs[0] = on_msg;
          batch.msgs[1] = bend_msg;
          batch.count   = mmnv_pkg::CountW'(2);
        end
        default: begin
          batch.msgs[0] = bend_msg;
          batch.count   = mmnv_pkg::CountW'(1);
        end
      endcase
    end
  end

endmodule

@@ rtl/core/mmnv_msg_queue.sv @@
// Holds one decoded batch of messages and shifts them out one per cycle while out_stall is low.
// Uses mmnv_pkg msg_t and batch_t.
`timescale 1ns / 1ps

module mmnv_msg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mmnv_pkg::batch_t  batch,
  output logic              can_load_hold,
  output logic              out_valid,
  input  logic              out_stall,
  output mmnv_pkg::msg_t    out_msg
);

  mmnv_pkg::msg_t [mmnv_pkg::MaxMsgs-1:0] slot_r, slot_nxt;
  logic [mmnv_pkg::CountW-1:0]            count_r, count_nxt;
  logic                                   pop;

  assign out_valid = (count_r != '0);
  assign out_msg   = slot_r[0];
  assign pop       = out_valid && !out_stall;

  // Stall the input unless the queue is empty or its final message leaves now.
  assign can_load_hold = (count_r > mmnv_pkg::CountW'(1)) ||
                         ((count_r == mmnv_pkg::CountW'(1)) && out_stall);

  always_comb begin
    slot_nxt  = slot_r;
    count_nxt = count_r;
    if (load) begin
      slot_nxt  = batch.msgs;
      count_nxt = batch.count;
    end else if (pop) begin
      for (int i = 0; i < mmnv_pkg::MaxMsgs - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
      count_nxt = count_r - mmnv_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/core/mmnv_checker.sv @@
// Port-level checks for midi_mono_note_voicer_top, attached by bind.
// Uses mmnv_pkg status codes.
`timescale 1ns / 1ps

module mmnv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_status_byte,
  input logic [6:0]  out_data_one,
  input logic [6:0]  out_data_two,
  input logic [15:0] out_time_stamp,
  input logic        out_last
);

  // A held message must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status_byte) &&
      $stable(out_data_one) && $stable(out_data_two) &&
      $stable(out_time_stamp) && $stable(out_last))
    else $error("output message changed while stalled");

  // More messages of this transaction pending: no new transaction taken.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken while a batch is still draining");

  // Pitch bend always closes a transaction; note-on never does.
  a_bend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status_byte == mmnv_pkg::StBend) |-> out_last)
    else $error("pitch bend not marked last");

  a_on_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status_byte == mmnv_pkg::StNoteOn) |-> !out_last)
    else $error("note-on marked last");

  // Reset leaves no message pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind midi_mono_note_voicer_top mmnv_checker u_mmnv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status_byte (out_status_byte),
  .out_data_one    (out_data_one),
  .out_data_two    (out_data_two),
  .out_time_stamp  (out_time_stamp),
  .out_last        (out_last)
);
